/* design/bffl_pkg.sv */
// Shared types and constants for the best-fit free-slot table.
package bffl_pkg;

  // Default number of table entries.
  localparam int unsigned TABLE_DEPTH_DEF = 16;

  // Command codes carried in the cmd field of an input word.
  localparam logic CMD_INSERT = 1'b0;
  localparam logic CMD_ALLOC  = 1'b1;

  // Input word: one command.
  typedef struct packed {
    logic        cmd;
    logic [15:0] size;
    logic [31:0] offset;
  } bffl_req_t;

  // Output word: one result.
  typedef struct packed {
    logic        found;
    logic [31:0] slot_offset;
    logic        overflow;
    logic [4:0]  free_count;
  } bffl_rsp_t;

  // Controller states.
  typedef enum logic {
    ST_IDLE,
    ST_EXEC
  } bffl_state_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic capture;
    logic apply;
  } bffl_ctrl_t;

endpackage

/* design/bffl_ctrl.sv */
// Controller state machine that sequences one command through compare and update.
module bffl_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start,
  output logic                busy,
  output bffl_pkg::bffl_ctrl_t ctrl_o
);
  import bffl_pkg::*;

  bffl_state_e state_q, state_d;

  // Next-state logic.
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (start) state_d = ST_EXEC;
      end
      ST_EXEC: state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  // Output logic.
  always_comb begin
    busy           = 1'b0;
    ctrl_o.capture = 1'b0;
    ctrl_o.apply   = 1'b0;
    case (state_q)
      ST_IDLE: begin
        ctrl_o.capture = start;
      end
      ST_EXEC: begin
        busy         = 1'b1;
        ctrl_o.apply = 1'b1;
      end
      default: begin
        busy = 1'b0;
      end
    endcase
  end

  // State register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

/* design/bffl_dpath.sv */
// Datapath: a chain of slot cells with parallel compare, shift update and result register.
module bffl_dpath #(
  parameter int unsigned TableDepth = bffl_pkg::TABLE_DEPTH_DEF
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  bffl_pkg::bffl_ctrl_t ctrl_i,
  input  bffl_pkg::bffl_req_t  req_i,
  output logic                 done_o,
  output bffl_pkg::bffl_rsp_t  rsp_o
);
  import bffl_pkg::*;

  localparam int unsigned CntW = $clog2(TableDepth + 1);

  // Slot cells; only entries below the count are ever meaningful.
  logic [15:0]           size_q [TableDepth];
  logic [31:0]           off_q  [TableDepth];
  logic [CntW-1:0]       count_q, count_d;

  // Latched command and per-cell match vector.
  logic                  cmd_q;
  logic [15:0]           sz_q;
  logic [31:0]           offin_q;
  logic [TableDepth-1:0] key_d, key_q;
  logic [TableDepth-1:0] first;

  logic                  full;
  logic                  found;
  logic [31:0]           take_off;
  bffl_rsp_t             rsp_d, rsp_q;
  logic                  done_q;

  // Per-cell compare. For insert a cell matches when it is empty or holds a
  // larger slot; for allocate when it is filled and large enough. The table is
  // sorted, so the insert vector is monotonic; allocate sets one contiguous run.
  for (genvar i = 0; i < TableDepth; i++) begin : g_key
    logic valid;
    assign valid = (CntW'(i) < count_q);
    assign key_d[i] = (req_i.cmd == CMD_INSERT) ? (!valid || (size_q[i] > req_i.size))
                                                : (valid && (size_q[i] >= req_i.size));
    if (i == 0) begin : g_first0
      assign first[i] = key_q[i];
    end else begin : g_firstn
      assign first[i] = key_q[i] && !key_q[i-1];
    end
  end

  assign full  = (count_q == CntW'(TableDepth));
  assign found = |key_q;

  // Offset of the first fitting cell.
  always_comb begin
    take_off = '0;
    for (int unsigned i = 0; i < TableDepth; i++) begin
      take_off = take_off | (first[i] ? off_q[i] : 32'd0);
    end
  end

  // Count update and result word.
  always_comb begin
    count_d = count_q;
    rsp_d   = '0;
    if (cmd_q == CMD_INSERT) begin
      rsp_d.overflow = full;
      if (!full) count_d = count_q + CntW'(1);
    end else begin
      rsp_d.found = found;
      if (found) begin
        rsp_d.slot_offset = take_off;
        count_d           = count_q - CntW'(1);
      end
    end
    rsp_d.free_count = 5'(count_d);
  end

  // Cell updates: insert shifts matching cells up by one and drops the new
  // slot into the first matching cell; allocate pulls the tail down over
  // the taken cell.
  for (genvar i = 0; i < TableDepth; i++) begin : g_cell
    always_ff @(posedge clk_i) begin
      if (ctrl_i.apply && key_q[i]) begin
        if (cmd_q == CMD_INSERT) begin
          if (!full) begin
            if (first[i]) begin
              size_q[i] <= sz_q;
              off_q[i]  <= offin_q;
            end else if (i > 0) begin
              size_q[i] <= size_q[(i > 0) ? i - 1 : 0];
              off_q[i]  <= off_q[(i > 0) ? i - 1 : 0];
            end
          end
        end else if (i < TableDepth - 1) begin
          size_q[i] <= size_q[(i < TableDepth - 1) ? i + 1 : i];
          off_q[i]  <= off_q[(i < TableDepth - 1) ? i + 1 : i];
        end
      end
    end
  end

  // Command latch, match vector and result register.
  always_ff @(posedge clk_i) begin
    if (ctrl_i.capture) begin
      cmd_q   <= req_i.cmd;
      sz_q    <= req_i.size;
      offin_q <= req_i.offset;
      key_q   <= key_d;
    end
    if (ctrl_i.apply) begin
      rsp_q <= rsp_d;
    end
  end

  // Control state: slot count and result strobe.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      done_q  <= 1'b0;
    end else begin
      done_q <= ctrl_i.apply;
      if (ctrl_i.apply) count_q <= count_d;
    end
  end

  assign done_o = done_q;
  assign rsp_o  = rsp_q;

endmodule

/* design/best_fit_free_list_unit.sv */
// Best-fit free-slot table: an accepted start compares the request against every cell and
// latches the match vector; the update state then shifts the cells and loads the result.
// A new command is taken only while busy is low; busy is high during the update state.
// Each result is shown on done_o for one cycle; the receiver cannot stall it.
// Reset empties the table (count zero) and idles the controller; cell contents are not cleared.
module best_fit_free_list_unit #(
  parameter int unsigned TableDepth = bffl_pkg::TABLE_DEPTH_DEF
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start,
  output logic                busy,
  input  bffl_pkg::bffl_req_t req_i,
  output logic                done_o,
  output bffl_pkg::bffl_rsp_t rsp_o
);
  import bffl_pkg::*;

  bffl_ctrl_t ctrl;

  // Sequencer.
  bffl_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start  (start),
    .busy   (busy),
    .ctrl_o (ctrl)
  );

  // Slot cells and result register.
  bffl_dpath #(
    .TableDepth (TableDepth)
  ) u_dpath (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctrl_i (ctrl),
    .req_i  (req_i),
    .done_o (done_o),
    .rsp_o  (rsp_o)
  );

endmodule

/* tb/sv/tb_best_fit_free_list_unit.sv */
// Self-checking testbench for the best-fit free-slot table: directed words, then random traffic.
module tb_best_fit_free_list_unit;
  import bffl_pkg::*;

  localparam int unsigned SLOTS        = TABLE_DEPTH_DEF;
  localparam int unsigned RANDOM_WORDS = 1300;
  localparam int unsigned CYCLE_LIMIT  = 200000;
  localparam int unsigned DRAIN_EVERY  = 400;

  // Traffic flavor of one burst of random words.
  typedef enum int {
    MODE_FILL,
    MODE_DRAIN,
    MODE_MIX
  } traffic_mode_e;

  // One row of the directed plan; reps above one repeats the row with
  // a shrinking size and a rising offset.
  typedef struct packed {
    bffl_req_t w;
    int        reps;
    bit        typed;
    bffl_rsp_t want;
  } plan_row_t;

  logic      clk_i = 1'b0;
  logic      rst_ni = 1'b0;
  logic      start = 1'b0;
  logic      busy;
  bffl_req_t req_i = '0;
  logic      done_o;
  bffl_rsp_t rsp_o;

  // Expectation typed into the plan, carried alongside the word being offered.
  bit        row_typed = 1'b0;
  bffl_rsp_t row_want = '0;

  // Predicted table contents, in ascending size order.
  logic [15:0] held_size   [SLOTS];
  logic [31:0] held_offset [SLOTS];
  int unsigned held_count = 0;

  bffl_rsp_t   pending_q [$];
  int unsigned mismatches = 0;
  int unsigned cycle_count = 0;

  plan_row_t plan [13] = '{
    '{{CMD_ALLOC,  16'h0000, 32'h0000_0000}, 1, 1'b1, {1'b0, 32'h0000_0000, 1'b0, 5'd0}},
    '{{CMD_ALLOC,  16'hFFFF, 32'hFFFF_FFFF}, 1, 1'b1, {1'b0, 32'h0000_0000, 1'b0, 5'd0}},
    '{{CMD_INSERT, 16'h0000, 32'h0000_0000}, 1, 1'b1, {1'b0, 32'h0000_0000, 1'b0, 5'd1}},
    '{{CMD_INSERT, 16'hFFFF, 32'hFFFF_FFFF}, 1, 1'b1, {1'b0, 32'h0000_0000, 1'b0, 5'd2}},
    '{{CMD_INSERT, 16'h0100, 32'hA5A5_A5A5}, 1, 1'b1, {1'b0, 32'h0000_0000, 1'b0, 5'd3}},
    '{{CMD_INSERT, 16'h0100, 32'h5A5A_5A5A}, 1, 1'b1, {1'b0, 32'h0000_0000, 1'b0, 5'd4}},
    '{{CMD_ALLOC,  16'h0000, 32'h0000_0000}, 1, 1'b1, {1'b1, 32'h0000_0000, 1'b0, 5'd3}},
    '{{CMD_ALLOC,  16'h0100, 32'hFFFF_FFFF}, 1, 1'b0, '0},
    '{{CMD_ALLOC,  16'hFFFF, 32'h0000_0000}, 1, 1'b0, '0},
    '{{CMD_ALLOC,  16'hFFFF, 32'h1234_5678}, 1, 1'b0, '0},
    '{{CMD_INSERT, 16'h8000, 32'h0000_1000}, 15, 1'b0, '0},
    '{{CMD_INSERT, 16'h0001, 32'h0000_2000}, 1, 1'b1, {1'b0, 32'h0000_0000, 1'b1, 5'd16}},
    '{{CMD_ALLOC,  16'h0001, 32'h0000_0000}, 1, 1'b0, '0}
  };

  best_fit_free_list_unit dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start  (start),
    .busy   (busy),
    .req_i  (req_i),
    .done_o (done_o),
    .rsp_o  (rsp_o)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // Applies one word to the predicted table and returns the result it should give.
  function automatic bffl_rsp_t fit_table_apply(input bffl_req_t w);
    bffl_rsp_t   r;
    int unsigned pos;
    r   = '0;
    pos = 0;
    if (w.cmd == CMD_INSERT) begin
      if (held_count >= SLOTS) begin
        r.overflow = 1'b1;
      end else begin
        // A new slot lands after every slot of the same or smaller size.
        while (pos < held_count && held_size[pos] <= w.size) pos++;
        for (int unsigned i = held_count; i > pos; i--) begin
          held_size[i]   = held_size[i-1];
          held_offset[i] = held_offset[i-1];
        end
        held_size[pos]   = w.size;
        held_offset[pos] = w.offset;
        held_count++;
      end
    end else begin
      // The first slot that is big enough is the best fit.
      while (pos < held_count && held_size[pos] < w.size) pos++;
      if (pos < held_count) begin
        r.found       = 1'b1;
        r.slot_offset = held_offset[pos];
        for (int unsigned i = pos; i + 1 < held_count; i++) begin
          held_size[i]   = held_size[i+1];
          held_offset[i] = held_offset[i+1];
        end
        held_count--;
      end
    end
    r.free_count = 5'(held_count);
    return r;
  endfunction

  // Builds one random word; sizes cluster low so that equal sizes and close fits are common.
  function automatic bffl_req_t make_random_word(input traffic_mode_e mode);
    bffl_req_t   w;
    int unsigned pick;
    w.offset = $urandom;
    pick = $urandom_range(0, 99);
    case (mode)
      MODE_FILL:  w.cmd = (pick < 80) ? CMD_INSERT : CMD_ALLOC;
      MODE_DRAIN: w.cmd = (pick < 80) ? CMD_ALLOC : CMD_INSERT;
      default:    w.cmd = (pick < 50) ? CMD_INSERT : CMD_ALLOC;
    endcase
    pick = $urandom_range(0, 9);
    if (w.cmd == CMD_ALLOC && held_count != 0 && pick < 4) begin
      // Ask for an exact fit or one just past a held size.
      w.size = held_size[$urandom_range(0, held_count - 1)] + 16'($urandom_range(0, 1));
    end else begin
      case (pick)
        0:       w.size = 16'h0000;
        1:       w.size = 16'hFFFF;
        2, 3:    w.size = 16'($urandom);
        default: w.size = 16'($urandom_range(0, 63));
      endcase
    end
    return w;
  endfunction

  // Offers one word after an optional gap and returns at the falling edge after it is taken.
  task automatic send_word(input bffl_req_t w, input bit typed, input bffl_rsp_t want,
                           input int unsigned gap);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    start     <= 1'b1;
    req_i     <= w;
    row_typed <= typed;
    row_want  <= want;
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  // Holds the sender off until every expected result has come back.
  task automatic wait_for_drain();
    start <= 1'b0;
    @(negedge clk_i);
    while (pending_q.size() != 0) @(negedge clk_i);
  endtask

  task automatic check_field(input string name, input logic [31:0] want_v,
                             input logic [31:0] got_v);
    if (got_v !== want_v) begin
      $display("%0t: %s expected %h, got %h", $time, name, want_v, got_v);
      mismatches++;
    end
  endtask

  // Scoreboard: results are checked before the word taken at the same edge is predicted.
  always @(posedge clk_i) begin : scoreboard
    bffl_rsp_t want;
    if (rst_ni) begin
      if (done_o) begin
        if (pending_q.size() == 0) begin
          $display("%0t: result %h with nothing expected", $time, rsp_o);
          mismatches++;
        end else begin
          want = pending_q.pop_front();
          check_field("found", 32'(want.found), 32'(rsp_o.found));
          check_field("slot_offset", want.slot_offset, rsp_o.slot_offset);
          check_field("overflow", 32'(want.overflow), 32'(rsp_o.overflow));
          check_field("free_count", 32'(want.free_count), 32'(rsp_o.free_count));
        end
      end
      if (start && !busy) begin
        want = fit_table_apply(req_i);
        pending_q.push_back(row_typed ? row_want : want);
      end
    end
  end

  // Watchdog on the total run length.
  initial begin : watchdog
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("CHECK FAILED");
    $finish;
  end

  initial begin : stimulus
    bffl_req_t     w;
    traffic_mode_e mode;
    int unsigned   burst_left;
    int unsigned   gap;
    mode       = MODE_MIX;
    burst_left = 0;
    repeat (11) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Directed words: empty table, extremes, equal sizes, a full table and overflow.
    foreach (plan[r]) begin
      for (int k = 0; k < plan[r].reps; k++) begin
        w        = plan[r].w;
        w.size   = w.size - 16'(k * 37);
        w.offset = w.offset + 32'(k);
        send_word(w, plan[r].typed, plan[r].want, (r % 3 == 2) ? 1 : 0);
      end
    end

    // Random bursts that each fill, drain or mix the table, in a mode picked at random.
    for (int unsigned n = 0; n < RANDOM_WORDS; n++) begin
      if (n != 0 && n % DRAIN_EVERY == 0) wait_for_drain();
      if (burst_left == 0) begin
        burst_left = $urandom_range(1, 40);
        mode       = traffic_mode_e'($urandom_range(0, 2));
        gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      end else begin
        gap = 0;
      end
      send_word(make_random_word(mode), 1'b0, '0, gap);
      burst_left--;
    end

    wait_for_drain();
    repeat (8) @(negedge clk_i);
    if (mismatches == 0 && pending_q.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

/* sim.f */
design/bffl_pkg.sv
design/bffl_ctrl.sv
design/bffl_dpath.sv
design/best_fit_free_list_unit.sv
tb/sv/tb_best_fit_free_list_unit.sv
